// ===== hw/rtl/asd_pkg.sv =====
`default_nettype none
package asd_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int IP_W      = 32;
   localparam int MAC_W     = 48;
   localparam int ENTRY_W   = IP_W + MAC_W;
   localparam int RSP_IDX_W = 6;

   // Command queue between front and back (power of two)
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Request operation codes
   localparam logic OP_OBSERVE = 1'b0;
   localparam logic OP_PRELOAD = 1'b1;

   // Command kinds decided by the front
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_SKIP    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OBSERVE = 2'd2;

   typedef struct packed {
      logic             operation;
      logic [IP_W-1:0]  sender_ip;
      logic [MAC_W-1:0] sender_mac;
   } req_type;

   typedef struct packed {
      logic                 spoof_detected;
      logic                 known_sender;
      logic                 stored;
      logic                 table_full;
      logic [RSP_IDX_W-1:0] entry_index;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
   } cmd_type;

   // Low bits of a table index as reported on the result
   function automatic logic [RSP_IDX_W-1:0] to_rsp_idx(input logic [IDX_W-1:0] idx);
      logic [IDX_W+RSP_IDX_W-1:0] wide;
      wide = {{RSP_IDX_W{1'b0}}, idx};
      return wide[RSP_IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/asd_ram.sv =====
`default_nettype none
module asd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/asd_front.sv =====
`default_nettype none
module asd_front
   import asd_pkg::*;
(
   input  wire logic    start,
   input  wire req_type req_data,
   input  wire logic    q_full,
   output logic         busy,
   output logic         q_push,
   output cmd_type      q_cmd
);

   assign busy   = q_full;
   assign q_push = start && !q_full;

   // preload with all-zero MAC does nothing but answer
   always_comb begin
      q_cmd.ip  = req_data.sender_ip;
      q_cmd.mac = req_data.sender_mac;
      if (req_data.operation == OP_PRELOAD) begin
         q_cmd.kind = (req_data.sender_mac == '0) ? KIND_SKIP : KIND_APPEND;
      end else begin
         q_cmd.kind = KIND_OBSERVE;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/asd_queue.sv =====
`default_nettype none
module asd_queue
   import asd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         not_empty,
   output cmd_type      head_cmd
);

   cmd_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/asd_back.sv =====
`default_nettype none
module asd_back
   import asd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_not_empty,
   input  wire cmd_type q_head,
   output logic         q_pop,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_SEARCH = 1'b1;

   logic             state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0] cmp_ptr_ff, cmp_ptr_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   logic             do_append;
   logic [IP_W-1:0]  app_ip;
   logic [MAC_W-1:0] app_mac;
   logic [IP_W-1:0]  rd_ip;
   logic [MAC_W-1:0] rd_mac;
   logic             last_cmp;

   assign rd_ip    = rd_data[ENTRY_W-1 -: IP_W];
   assign rd_mac   = rd_data[MAC_W-1:0];
   assign last_cmp = ({{(CNT_W-IDX_W){1'b0}}, cmp_ptr_ff} == count_ff - CNT_W'(1));

   asd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      cmp_ptr_in   = cmp_ptr_ff;
      cmp_valid_in = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = {cmd_ff.ip, cmd_ff.mac};
      rd_addr      = rd_ptr_ff[IDX_W-1:0];
      do_append    = 1'b0;
      app_ip       = cmd_ff.ip;
      app_mac      = cmd_ff.mac;

      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               q_pop   = 1'b1;
               cmd_in  = q_head;
               app_ip  = q_head.ip;
               app_mac = q_head.mac;
               case (q_head.kind)
                  KIND_APPEND: begin
                     do_append = 1'b1;
                  end
                  KIND_OBSERVE: begin
                     if (count_ff == '0) begin
                        do_append = 1'b1;
                     end else begin
                        rd_ptr_in = '0;
                        state_in  = ST_SEARCH;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (cmp_valid_ff && rd_ip == cmd_ff.ip) begin
               // hit: refresh MAC in place
               wr_en                      = 1'b1;
               wr_addr                    = cmp_ptr_ff;
               rsp_valid_in               = 1'b1;
               rsp_data_in.spoof_detected = (rd_mac != cmd_ff.mac);
               rsp_data_in.known_sender   = 1'b1;
               rsp_data_in.stored         = 1'b1;
               rsp_data_in.entry_index    = to_rsp_idx(cmp_ptr_ff);
               state_in                   = ST_IDLE;
            end else if (cmp_valid_ff && last_cmp) begin
               do_append = 1'b1;
               state_in  = ST_IDLE;
            end else if (rd_ptr_ff < count_ff) begin
               cmp_valid_in = 1'b1;
               cmp_ptr_in   = rd_ptr_ff[IDX_W-1:0];
               rd_ptr_in    = rd_ptr_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_append) begin
         rsp_valid_in = 1'b1;
         if (count_ff < CNT_W'(TABLE_DEPTH)) begin
            wr_en                   = 1'b1;
            wr_addr                 = count_ff[IDX_W-1:0];
            wr_data                 = {app_ip, app_mac};
            count_in                = count_ff + CNT_W'(1);
            rsp_data_in.stored      = 1'b1;
            rsp_data_in.entry_index = to_rsp_idx(count_ff[IDX_W-1:0]);
         end else begin
            rsp_data_in.table_full = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rd_ptr_ff   <= rd_ptr_in;
      cmp_ptr_ff  <= cmp_ptr_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/arp_binding_spoof_detector.sv =====
`default_nettype none
// ARP binding spoof detector: learns IPv4-to-MAC bindings from ARP senders.
// Request channel: drive start with req_data; the transfer happens at the
//   clock edge where start is high and busy is low. busy rises only while
//   the two-entry command queue is full.
// Result channel: one result per request, on rsp_data for exactly one cycle
//   with rsp_valid high. The receiver cannot stall; every result is taken.
// Throughput: a preload, zero-MAC or not, is registered in the command queue
//   and answered from the result register once the back end takes it. An
//   observe walks the table one entry per cycle through the table RAM's
//   registered read port and stops early at the first match.
//   The back end takes one command at a time and finishes a preload without
//   leaving idle, so preloads sustain one transfer per cycle while no
//   observe is in progress; an observe holds the back end until its walk
//   ends. Up to two further requests wait in the queue.
// Full table: new bindings are dropped with table_full set; an observe that
//   matches still refreshes its entry.
// Reset (synchronous, active high) empties the queue, clears the entry count
//   and idles the back end. Table RAM contents are not cleared; only entries
//   below the entry count are ever compared.
module arp_binding_spoof_detector
   import asd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_not_empty;
   cmd_type q_in_cmd;
   cmd_type q_head;

   // front: handshake and classification
   asd_front u_front (
      .start    (start),
      .req_data (req_data),
      .q_full   (q_full),
      .busy     (busy),
      .q_push   (q_push),
      .q_cmd    (q_in_cmd)
   );

   // short decoupling queue
   asd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_in_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (q_head)
   );

   // back: table search, update and append
   asd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

// ===== tb/asd_binding_checker.sv =====
`timescale 1ns / 1ps
module asd_binding_checker
   import asd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding,
   output int      spoofs_seen,
   output int      hits_seen,
   output int      drops_seen
);

   // Shadow binding table
   logic [IP_W-1:0]  bound_ip  [TABLE_DEPTH];
   logic [MAC_W-1:0] bound_mac [TABLE_DEPTH];
   int               bound_count;

   rsp_type awaited_verdicts[$];
   rsp_type oldest;
   int      fail_tally;
   int      spoof_tally;
   int      hit_tally;
   int      drop_tally;

   function automatic rsp_type append_binding(input req_type req);
      rsp_type verdict;
      verdict = '0;
      if (bound_count >= TABLE_DEPTH) begin
         verdict.table_full = 1'b1;
      end else begin
         bound_ip[bound_count]  = req.sender_ip;
         bound_mac[bound_count] = req.sender_mac;
         verdict.stored         = 1'b1;
         verdict.entry_index    = RSP_IDX_W'(bound_count);
         bound_count++;
      end
      return verdict;
   endfunction

   // First match wins; duplicates from preloads shadow nothing.
   function automatic rsp_type resolve_binding(input req_type req);
      rsp_type verdict;
      int      i;
      bit      hit;
      verdict = '0;
      hit     = 1'b0;
      if (req.operation == OP_PRELOAD) begin
         if (req.sender_mac != '0) begin
            verdict = append_binding(req);
         end
      end else begin
         for (i = 0; i < bound_count && !hit; i++) begin
            if (bound_ip[i] == req.sender_ip) begin
               hit                    = 1'b1;
               verdict.spoof_detected = (bound_mac[i] != req.sender_mac);
               verdict.known_sender   = 1'b1;
               verdict.stored         = 1'b1;
               verdict.entry_index    = RSP_IDX_W'(i);
               bound_mac[i]           = req.sender_mac;
            end
         end
         if (!hit) begin
            verdict = append_binding(req);
         end
      end
      return verdict;
   endfunction

   // One line per mismatch, and a running count.
   task automatic flag_mismatch(input string what, input logic [63:0] seen,
                                input logic [63:0] wanted);
      fail_tally++;
      $display("[%0t] mismatch, %s: got %0h, expected %0h", $realtime, what, seen, wanted);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         awaited_verdicts.delete();
         bound_count = 0;
         fail_tally  = 0;
         spoof_tally = 0;
         hit_tally   = 0;
         drop_tally  = 0;
      end else begin
         // A result can never belong to a transfer of the same edge,
         // so it is matched before that transfer is predicted.
         if (rsp_valid === 1'b1) begin
            if (awaited_verdicts.size() == 0) begin
               flag_mismatch("result with nothing pending", 64'(rsp_data), 64'd0);
            end else begin
               oldest = awaited_verdicts.pop_front();
               if (rsp_data.spoof_detected !== oldest.spoof_detected)
                  flag_mismatch("spoof_detected", 64'(rsp_data.spoof_detected),
                                64'(oldest.spoof_detected));
               if (rsp_data.known_sender !== oldest.known_sender)
                  flag_mismatch("known_sender", 64'(rsp_data.known_sender),
                                64'(oldest.known_sender));
               if (rsp_data.stored !== oldest.stored)
                  flag_mismatch("stored", 64'(rsp_data.stored), 64'(oldest.stored));
               if (rsp_data.table_full !== oldest.table_full)
                  flag_mismatch("table_full", 64'(rsp_data.table_full),
                                64'(oldest.table_full));
               if (rsp_data.entry_index !== oldest.entry_index)
                  flag_mismatch("entry_index", 64'(rsp_data.entry_index),
                                64'(oldest.entry_index));
               spoof_tally += oldest.spoof_detected;
               hit_tally   += oldest.known_sender;
               drop_tally  += oldest.table_full;
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            awaited_verdicts.push_back(resolve_binding(req_data));
         end
      end
      mismatches  <= fail_tally;
      outstanding <= awaited_verdicts.size();
      spoofs_seen <= spoof_tally;
      hits_seen   <= hit_tally;
      drops_seen  <= drop_tally;
   end

endmodule

// ===== tb/arp_binding_spoof_detector_tb.sv =====
`timescale 1ns / 1ps
module arp_binding_spoof_detector_tb;
   import asd_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int PHASES       = 4;
   localparam int POOL_SIZE    = 40;    // recurring senders, so observes hit often
   localparam int MAX_GAP      = 16;
   localparam int DRAIN_CYCLES = 100;   // covers the longest observe, a full-table walk
   // Slowest run: 1512 transfers, each with a maximal idle run and a full-table walk.
   localparam int CYCLE_LIMIT  = 800000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   int mismatches;
   int outstanding;
   int spoofs_seen;
   int hits_seen;
   int drops_seen;

   int cycle_count   = 0;
   int transfers     = 0;
   int preloads_sent = 0;

   logic [IP_W-1:0]  ip_pool  [POOL_SIZE];
   logic [MAC_W-1:0] mac_pool [POOL_SIZE][2];

   arp_binding_spoof_detector u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // Watches both channels, predicts every result and compares.
   asd_binding_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .outstanding(outstanding),
      .spoofs_seen(spoofs_seen),
      .hits_seen  (hits_seen),
      .drops_seen (drops_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [MAC_W-1:0] random_mac();
      return MAC_W'({$urandom, $urandom});
   endfunction

   function automatic req_type binding_req(input logic op, input logic [IP_W-1:0] ip,
                                           input logic [MAC_W-1:0] mac);
      req_type item;
      item.operation  = op;
      item.sender_ip  = ip;
      item.sender_mac = mac;
      return item;
   endfunction

   // Geometric idle run; idle_pct is the chance of one more idle cycle.
   function automatic int draw_gap(input int idle_pct);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      return gap;
   endfunction

   // Mostly pool senders with one of two MACs each, so repeat observes
   // split between quiet refreshes and spoofs; some fresh IPs keep
   // appending until the table fills, after which new ones are dropped.
   function automatic req_type draw_request();
      req_type item;
      int      slot;
      int      pick;
      slot = $urandom_range(POOL_SIZE - 1);
      item.operation = ($urandom_range(99) < 15) ? OP_PRELOAD : OP_OBSERVE;
      item.sender_ip = ($urandom_range(99) < 12) ? IP_W'($urandom) : ip_pool[slot];
      pick = $urandom_range(19);
      if (pick == 0)
         item.sender_mac = '0;   // skipped preload, or an all-zero binding
      else if (pick <= 2)
         item.sender_mac = random_mac();
      else
         item.sender_mac = mac_pool[slot][$urandom_range(1)];
      return item;
   endfunction

   // One transfer: optional idle run with start low, then hold start and the
   // payload until an edge sees busy low. start stays high back to back.
   task automatic send_request(input req_type item, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      transfers++;
      if (item.operation == OP_PRELOAD) preloads_sent++;
   endtask

   // Sender holds off until every pending result has come back.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      req_type plan[$];
      int      idle_pct;
      int      phase;
      int      n;

      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      for (n = 0; n < POOL_SIZE; n++) begin
         ip_pool[n]     = IP_W'($urandom);
         mac_pool[n][0] = random_mac();
         mac_pool[n][1] = random_mac();
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed opening on an empty table.
      // observe miss with all-zero fields appends entry 0
      plan.push_back(binding_req(OP_OBSERVE, '0, '0));
      // same binding again: known, no spoof
      plan.push_back(binding_req(OP_OBSERVE, '0, '0));
      // same IP, all-ones MAC: spoof, entry 0 overwritten
      plan.push_back(binding_req(OP_OBSERVE, '0, '1));
      // preload with all-ones fields appends entry 1
      plan.push_back(binding_req(OP_PRELOAD, '1, '1));
      // zero-MAC preload writes nothing, all result fields low
      plan.push_back(binding_req(OP_PRELOAD, 32'h0A0B_0C0D, '0));
      // preload of a present IP appends a duplicate at entry 2
      plan.push_back(binding_req(OP_PRELOAD, '1, 48'h0000_0000_0001));
      // observe takes the first copy (entry 1) and flags the MAC change
      plan.push_back(binding_req(OP_OBSERVE, '1, 48'h0000_0000_0001));
      plan.push_back(binding_req(OP_OBSERVE, '1, 48'h0000_0000_0001));
      // alternating bit patterns
      plan.push_back(binding_req(OP_OBSERVE, 32'hA5A5_A5A5, 48'h5A5A_5A5A_5A5A));
      plan.push_back(binding_req(OP_PRELOAD, 32'h5A5A_5A5A, 48'hA5A5_A5A5_A5A5));
      plan.push_back(binding_req(OP_OBSERVE, 32'h5A5A_5A5A, 48'hA5A5_A5A5_A5A5));
      plan.push_back(binding_req(OP_OBSERVE, 32'hA5A5_A5A5, 48'hA5A5_A5A5_A5A5));
      foreach (plan[k]) send_request(plan[k], 0);
      drain_results();

      // Random part. The table fills early on; the rest runs against a full
      // table, where misses and preloads are dropped and hits still refresh.
      // Phases: back to back, sparse sender, moderate sender, and bursts
      // alternating between back to back and sparse.
      for (phase = 0; phase < PHASES; phase++) begin
         for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            case (phase)
               0: idle_pct = 0;
               1: idle_pct = 77;
               2: idle_pct = 38;
               default: idle_pct = ((n / 40) % 2 == 1) ? 77 : 0;
            endcase
            send_request(draw_request(), draw_gap(idle_pct));
         end
         drain_results();
      end

      // Let any stray result surface before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d transfers (%0d preloads) over four pacing phases",
               transfers, preloads_sent);
      $display("%0d known senders, %0d spoofs, %0d dropped on full table",
               hits_seen, spoofs_seen, drops_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/asd_pkg.sv
hw/rtl/asd_ram.sv
hw/rtl/asd_front.sv
hw/rtl/asd_queue.sv
hw/rtl/asd_back.sv
hw/rtl/arp_binding_spoof_detector.sv
tb/asd_binding_checker.sv
tb/arp_binding_spoof_detector_tb.sv
